// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, sampled on clock and idle during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hw/rtl/tcpu_pkg.sv -----
package tcpu_pkg;

   localparam int OPCODE_W  = 8;
   localparam int OPERAND_W = 8;
   localparam int DATA_W    = 16;
   localparam int FLAGS_W   = 12;
   localparam int FAULT_W   = 2;

   localparam logic [OPCODE_W-1:0] OP_ADD = 8'd1;
   localparam logic [OPCODE_W-1:0] OP_SUB = 8'd2;
   localparam logic [OPCODE_W-1:0] OP_MUL = 8'd3;
   localparam logic [OPCODE_W-1:0] OP_DIV = 8'd4;
   localparam logic [OPCODE_W-1:0] OP_INC = 8'd5;
   localparam logic [OPCODE_W-1:0] OP_DEC = 8'd6;
   localparam logic [OPCODE_W-1:0] OP_MOV = 8'd11;
   localparam logic [OPCODE_W-1:0] OP_JMP = 8'd14;

   localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_REG  = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_DIV  = 2'd2;

   localparam int FLAG_PARITY_BIT = 2;
   localparam int FLAG_ZERO_BIT   = 6;
   localparam int FLAG_SIGN_BIT   = 7;
   localparam int FLAG_OVER_BIT   = 11;

   localparam logic [2:0] CODE_ZERO = 3'd0;
   localparam logic [2:0] CODE_MAX  = 3'd4;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RD_TGT = 7'b0000010,
      ST_RD_OTH = 7'b0000100,
      ST_CALC   = 7'b0001000,
      ST_ITER   = 7'b0010000,
      ST_WB     = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   function automatic logic code_ok(input logic [2:0] code);
      return code <= CODE_MAX;
   endfunction

   function automatic logic [FLAGS_W-1:0] flags_of(input logic [DATA_W-1:0] r);
      logic [FLAGS_W-1:0] f;
      f = '0;
      f[FLAG_ZERO_BIT]   = (r == '0);
      f[FLAG_SIGN_BIT]   = r[DATA_W-1];
      f[FLAG_OVER_BIT]   = r[DATA_W-1];
      f[FLAG_PARITY_BIT] = ~^r;
      return f;
   endfunction

endpackage

// ----- hw/rtl/tcpu_channels.sv -----
interface tcpu_req_if;
   import tcpu_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [OPERAND_W-1:0] operand;

   modport source (output valid, opcode, operand, input ready);
   modport sink   (input valid, opcode, operand, output ready);
endinterface

interface tcpu_rsp_if;
   import tcpu_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  target_value;
   logic [FLAGS_W-1:0] flag_bits;
   logic [DATA_W-1:0]  next_pc;
   logic [FAULT_W-1:0] fault;

   modport source (output valid, target_value, flag_bits, next_pc, fault, input ready);
   modport sink   (input valid, target_value, flag_bits, next_pc, fault, output ready);
endinterface

// ----- hw/rtl/toy_cpu_execute_unit.sv -----
// channel   dir   handshake          payload
// req_bus   in    valid / ready      opcode[7:0], operand[7:0]
// rsp_bus   out   valid / ready      target_value[15:0], flag_bits[11:0], next_pc[15:0], fault[1:0]
//
// one request at a time: ready is high only while idle
// add, sub, inc, dec, mov: RD_TGT, RD_OTH, CALC, WB, then DONE; jmp and no-ops skip WB
// mul and div: the shared adder steps one bit per cycle for 16 steps in ITER, then WB
// register faults and a zero divisor go from CALC straight to DONE, skipping WB
// once the response is taken the unit returns to idle, where the next request is taken
// the response holds until taken; synchronous reset invalidates registers, clears flags and pc
`include "assert_macros.svh"

module toy_cpu_execute_unit (
   input logic        clock,
   input logic        reset,
   tcpu_req_if.sink   req_bus,
   tcpu_rsp_if.source rsp_bus
);
   import tcpu_pkg::*;

   state_type             state_ff, state_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [OPERAND_W-1:0]  arg_ff, arg_in;
   logic [DATA_W-1:0]     a_ff, a_in;
   logic [DATA_W-1:0]     b_ff, b_in;
   logic [DATA_W-1:0]     acc_ff, acc_in;
   logic [DATA_W-1:0]     res_ff, res_in;
   logic [DATA_W-1:0]     tv_ff, tv_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [FAULT_W-1:0]    fault_ff, fault_in;
   logic [FLAGS_W-1:0]    flags_ff, flags_in;
   logic [DATA_W-1:0]     pc_ff, pc_in;

   logic [DATA_W-1:0]     regfile_mem [4];
   logic [3:0]            mem_valid_ff;
   logic [DATA_W-1:0]     rd_data_ff;
   logic                  rd_ok_ff;

   logic [2:0]            tgt, oth, rd_code;
   logic [1:0]            rd_addr, wr_addr;
   logic [DATA_W-1:0]     rd_value, wb_value, wv;
   logic                  is_arith, two_regs, wr_en;

   logic [DATA_W:0]       alu_x, alu_y;
   logic                  alu_sub;
   logic [DATA_W+1:0]     alu_sum;

   assign tgt      = arg_ff[5:3];
   assign oth      = arg_ff[2:0];
   assign rd_code  = (state_ff == ST_RD_TGT) ? tgt : oth;
   assign rd_addr  = rd_code[1:0] - 2'd1;
   assign wr_addr  = tgt[1:0] - 2'd1;
   assign rd_value = rd_ok_ff ? rd_data_ff : '0;

   always_comb begin
      case (op_ff)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOV: begin
            is_arith = 1'b1;
            two_regs = 1'b1;
         end
         OP_INC, OP_DEC: begin
            is_arith = 1'b1;
            two_regs = 1'b0;
         end
         default: begin
            is_arith = 1'b0;
            two_regs = 1'b0;
         end
      endcase
   end

   // shared adder / subtractor
   always_comb begin
      alu_x   = {1'b0, a_ff};
      alu_y   = {1'b0, rd_value};
      alu_sub = 1'b0;
      if (state_ff == ST_ITER) begin
         if (op_ff == OP_MUL) begin
            alu_x = {1'b0, acc_ff};
            alu_y = {1'b0, a_ff};
         end else begin
            alu_x   = {acc_ff, a_ff[DATA_W-1]};
            alu_y   = {1'b0, b_ff};
            alu_sub = 1'b1;
         end
      end else begin
         case (op_ff)
            OP_SUB: alu_sub = 1'b1;
            OP_INC: alu_y = (DATA_W+1)'(1);
            OP_DEC: begin
               alu_y   = (DATA_W+1)'(1);
               alu_sub = 1'b1;
            end
            default: alu_sub = 1'b0;
         endcase
      end
   end

   assign alu_sum = {1'b0, alu_x} + {1'b0, alu_y ^ {(DATA_W+1){alu_sub}}}
                  + (DATA_W+2)'(alu_sub);

   always_comb begin
      case (op_ff)
         OP_MUL:  wb_value = acc_ff;
         OP_DIV:  wb_value = a_ff;
         default: wb_value = res_ff;
      endcase
   end

   assign wv    = (tgt == CODE_ZERO) ? '0 : wb_value;
   assign wr_en = (state_ff == ST_WB) && (tgt != CODE_ZERO);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      arg_in   = arg_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      tv_in    = tv_ff;
      cnt_in   = cnt_ff;
      fault_in = fault_ff;
      flags_in = flags_ff;
      pc_in    = pc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.opcode;
               arg_in   = req_bus.operand;
               state_in = ST_RD_TGT;
            end
         end
         ST_RD_TGT: begin
            state_in = ST_RD_OTH;
         end
         ST_RD_OTH: begin
            a_in     = rd_value;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            fault_in = FAULT_NONE;
            b_in     = rd_value;
            tv_in    = a_ff;
            state_in = ST_DONE;
            if (is_arith) begin
               if (!code_ok(tgt) || (two_regs && !code_ok(oth))) begin
                  fault_in = FAULT_REG;
               end else begin
                  case (op_ff)
                     OP_MOV: begin
                        res_in   = rd_value;
                        state_in = ST_WB;
                     end
                     OP_MUL: begin
                        acc_in   = '0;
                        cnt_in   = 4'd15;
                        state_in = ST_ITER;
                     end
                     OP_DIV: begin
                        if (rd_value == '0) begin
                           fault_in = FAULT_DIV;
                        end else begin
                           acc_in   = '0;
                           cnt_in   = 4'd15;
                           state_in = ST_ITER;
                        end
                     end
                     default: begin
                        res_in   = alu_sum[DATA_W-1:0];
                        state_in = ST_WB;
                     end
                  endcase
               end
            end else if (op_ff == OP_JMP) begin
               pc_in = {{(DATA_W-OPERAND_W){1'b0}}, arg_ff} + DATA_W'(2);
            end else begin
               pc_in = pc_ff + DATA_W'(2);
            end
         end
         ST_ITER: begin
            if (op_ff == OP_MUL) begin
               if (b_ff[0]) begin
                  acc_in = alu_sum[DATA_W-1:0];
               end
               a_in = {a_ff[DATA_W-2:0], 1'b0};
               b_in = {1'b0, b_ff[DATA_W-1:1]};
            end else if (alu_sum[DATA_W+1]) begin
               acc_in = alu_sum[DATA_W-1:0];
               a_in   = {a_ff[DATA_W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[DATA_W-2:0], a_ff[DATA_W-1]};
               a_in   = {a_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            tv_in    = wv;
            flags_in = flags_of(wv);
            pc_in    = pc_ff + DATA_W'(2);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fault_ff <= FAULT_NONE;
         flags_ff <= '0;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         fault_ff <= fault_in;
         flags_ff <= flags_in;
         pc_ff    <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      arg_ff <= arg_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      tv_ff  <= tv_in;
      cnt_ff <= cnt_in;
   end

   // register file, one read port with registered data
   always_ff @(posedge clock) begin
      rd_data_ff <= regfile_mem[rd_addr];
      if (wr_en) begin
         regfile_mem[wr_addr] <= wv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         rd_ok_ff <= mem_valid_ff[rd_addr] && (rd_code != CODE_ZERO) && code_ok(rd_code);
         if (wr_en) begin
            mem_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = (state_ff == ST_DONE);
   assign rsp_bus.target_value = tv_ff;
   assign rsp_bus.flag_bits    = flags_ff;
   assign rsp_bus.next_pc      = pc_ff;
   assign rsp_bus.fault        = fault_ff;

   `ASSERT_NEXT(a_iter_end, state_ff == ST_ITER && cnt_ff == '0, state_ff == ST_WB, "iter overrun")
   `ASSERT_IMPL(a_div_fault, rsp_bus.valid && fault_ff == FAULT_DIV, op_ff == OP_DIV, "bad div fault")
   `ASSERT_NEXT(a_busy, req_bus.valid && req_bus.ready, !req_bus.ready, "still ready")

endmodule
